### sv/mcv_pkg.sv
// Shared constants, register codes and beat types of the metronome click voice.
`timescale 1ns / 1ps

package mcv_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS         = 16;
  localparam int STEP_BITS           = 32;
  localparam int LEVEL_BITS          = 24;
  localparam int CFG_IDX_BITS        = 3;
  localparam int CFG_DATA_BITS       = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCENT_STEP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEAT_STEP     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCENT_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEAT_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE_LEVEL = 3'd5;

  // Register values after reset
  localparam logic [STEP_BITS-1:0]  ACCENT_STEP_RST   = 32'd78741067;
  localparam logic [STEP_BITS-1:0]  BEAT_STEP_RST     = 32'd39370534;
  localparam logic [LEVEL_BITS-1:0] ACCENT_LEVEL_RST  = 24'd8388608;
  localparam logic [LEVEL_BITS-1:0] BEAT_LEVEL_RST    = 24'd5872026;
  localparam logic [LEVEL_BITS-1:0] DECAY_FACTOR_RST  = 24'd16763236;
  localparam logic [LEVEL_BITS-1:0] SILENCE_LEVEL_RST = 24'd1678;

  // Number of result stages between the input and output handshakes
  localparam int PIPE_DEPTH = 3;

  typedef struct packed {
    logic                          click_start;
    logic                          accent;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          voice_on;
  } mix_t;

endpackage

### sv/mcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/mcv_sine_fill.sv
// Quarter-wave sine table builder: odd polynomial per entry on one shared multiplier.
`timescale 1ns / 1ps

module mcv_sine_fill #(
  parameter int SINE_TABLE_BITS = mcv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             wr_en,
  output logic [SINE_TABLE_BITS:0]         wr_addr,
  output logic [mcv_pkg::LEVEL_BITS-1:0]   wr_data,
  output logic                             done
);

  localparam int QTR_LEN = 1 << SINE_TABLE_BITS;
  localparam int AW      = SINE_TABLE_BITS + 1;
  localparam int XSH     = 30 - SINE_TABLE_BITS;
  localparam int LB      = mcv_pkg::LEVEL_BITS;

  // Q2.30 coefficients of the odd polynomial
  localparam logic signed [33:0] C1 = 34'sd1686629713;
  localparam logic signed [33:0] C3 = 34'sd693598668;
  localparam logic signed [33:0] C5 = 34'sd85569306;
  localparam logic signed [33:0] C7 = 34'sd5026993;
  localparam logic signed [33:0] C9 = 34'sd172273;
  localparam logic [2:0]          LAST_TERM = 3'd4;

  typedef enum logic [5:0] {
    S_SQ   = 6'b000001,
    S_X2   = 6'b000010,
    S_MUL  = 6'b000100,
    S_ADD  = 6'b001000,
    S_OUT  = 6'b010000,
    S_DONE = 6'b100000
  } fill_state_t;

  function automatic logic signed [33:0] horner_coef(input logic [1:0] sel);
    logic signed [33:0] c;
    case (sel)
      2'd0:    c = -C7;
      2'd1:    c = C5;
      2'd2:    c = -C3;
      default: c = C1;
    endcase
    return c;
  endfunction

  fill_state_t        state;
  logic [AW-1:0]      k;
  logic [2:0]         term;
  logic signed [33:0] t;
  logic signed [31:0] x2;
  logic signed [65:0] prod;

  logic signed [31:0] x;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [35:0] prod_sh;
  logic signed [33:0] fin;
  logic signed [33:0] fin_rnd;
  logic [27:0]        fin_q24;

  assign x       = signed'(32'(k) << XSH);
  assign mul_a   = (state == S_SQ) ? 34'(x) : t;
  assign mul_b   = ((state == S_SQ) || (term == LAST_TERM)) ? x : x2;
  assign prod_sh = prod[65:30];
  assign fin     = prod_sh[33:0];
  assign fin_rnd = fin + 34'sd32;
  assign fin_q24 = fin_rnd[33:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SQ;
      k     <= '0;
      term  <= '0;
    end else begin
      unique case (state)
        S_SQ:  state <= S_X2;
        S_X2: begin
          term  <= '0;
          state <= S_MUL;
        end
        S_MUL: state <= (term == LAST_TERM) ? S_OUT : S_ADD;
        S_ADD: begin
          term  <= term + 3'd1;
          state <= S_MUL;
        end
        S_OUT: begin
          k     <= k + AW'(1);
          state <= (k == AW'(QTR_LEN)) ? S_DONE : S_SQ;
        end
        S_DONE: state <= S_DONE;
        default: state <= S_SQ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SQ) || (state == S_MUL)) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_X2) begin
      x2 <= prod_sh[31:0];
      t  <= C9;
    end
    if (state == S_ADD) begin
      t <= horner_coef(term[1:0]) + prod_sh[33:0];
    end
  end

  always_comb begin
    if (fin <= 34'sd0) begin
      wr_data = '0;
    end else if (fin_q24 > 28'((1 << LB) - 1)) begin
      wr_data = '1;
    end else begin
      wr_data = fin_q24[LB-1:0];
    end
  end

  assign wr_en   = (state == S_OUT);
  assign wr_addr = k;
  assign done    = (state == S_DONE);

endmodule

### sv/metronome_click_voice.sv
// Top level of the metronome click voice: decaying sine click mixed onto a stereo stream.
`timescale 1ns / 1ps

// One stereo frame goes in per beat on the frame channel and one mixed frame
// comes out per beat on the mix channel, in order. The block takes a new
// frame every cycle while frame_ready is high. A frame's mix beat passes
// through table read, then click multiply, then mix and saturate into
// the output register. The three stages drain independently, so a
// stalled output does not block input until all of them are full. The
// per-frame recurrence on phase and envelope (one 24 x 24 envelope multiply
// and a compare) is combinational, from the state registers back into them.
// After reset the quarter-wave sine table is built in RAM, one entry at a
// time, and frame_ready stays low until all 2^SINE_TABLE_BITS + 1 entries
// are written. Configuration writes are taken every cycle and apply to
// frames accepted after the write; a frame already past the input keeps
// the values it was accepted with.

module metronome_click_voice #(
  parameter int SINE_TABLE_BITS = mcv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               frame_valid,
  output logic                               frame_ready,
  input  mcv_pkg::frame_t                    frame,
  output logic                               mix_valid,
  input  logic                               mix_ready,
  output mcv_pkg::mix_t                      mix,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mcv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB      = mcv_pkg::SAMPLE_BITS;
  localparam int LB      = mcv_pkg::LEVEL_BITS;
  localparam int PB      = mcv_pkg::STEP_BITS;
  localparam int QTR_LEN = 1 << SINE_TABLE_BITS;
  localparam int DEPTH   = QTR_LEN + 1;
  localparam int AW      = SINE_TABLE_BITS + 1;
  localparam int PW      = 2 * LB;
  localparam int SH      = 49 - SB;
  localparam int SW      = SB + 2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [PB-1:0] accent_step;
  logic [PB-1:0] beat_step;
  logic [LB-1:0] accent_level;
  logic [LB-1:0] beat_level;
  logic [LB-1:0] decay_factor;
  logic [LB-1:0] silence_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accent_step   <= mcv_pkg::ACCENT_STEP_RST;
      beat_step     <= mcv_pkg::BEAT_STEP_RST;
      accent_level  <= mcv_pkg::ACCENT_LEVEL_RST;
      beat_level    <= mcv_pkg::BEAT_LEVEL_RST;
      decay_factor  <= mcv_pkg::DECAY_FACTOR_RST;
      silence_level <= mcv_pkg::SILENCE_LEVEL_RST;
    end else if (cfg_valid) begin
      // Indexes past the last register drop the write.
      unique case (cfg_index)
        mcv_pkg::REG_ACCENT_STEP:   accent_step   <= cfg_data[PB-1:0];
        mcv_pkg::REG_BEAT_STEP:     beat_step     <= cfg_data[PB-1:0];
        mcv_pkg::REG_ACCENT_LEVEL:  accent_level  <= cfg_data[LB-1:0];
        mcv_pkg::REG_BEAT_LEVEL:    beat_level    <= cfg_data[LB-1:0];
        mcv_pkg::REG_DECAY_FACTOR:  decay_factor  <= cfg_data[LB-1:0];
        mcv_pkg::REG_SILENCE_LEVEL: silence_level <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sine table: built after reset, then read once per frame
  // ---------------------------------------------------------------------
  logic          fill_we;
  logic [AW-1:0] fill_addr;
  logic [LB-1:0] fill_data;
  logic          fill_done;
  logic          tab_re;
  logic [AW-1:0] tab_addr;
  logic [LB-1:0] tab_q;

  mcv_sine_fill #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fill_we),
    .wr_addr (fill_addr),
    .wr_data (fill_data),
    .done    (fill_done)
  );

  mcv_ram #(
    .WIDTH(LB),
    .DEPTH(DEPTH)
  ) u_tab (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (tab_re),
    .raddr (tab_addr),
    .rdata (tab_q)
  );

  // ---------------------------------------------------------------------
  // Stage handshakes: each stage loads when it is empty or its successor
  // is loading, so bubbles close up under an output stall.
  // ---------------------------------------------------------------------
  logic v1, v2;
  logic en1, en2, en_o;
  logic take;

  assign en_o        = !mix_valid || mix_ready;
  assign en2         = !v2 || en_o;
  assign en1         = !v1 || en2;
  assign frame_ready = en1 && fill_done;
  assign take        = frame_valid && frame_ready;

  // ---------------------------------------------------------------------
  // Voice state and its combinational recurrence
  // ---------------------------------------------------------------------
  logic [PB-1:0] phase;
  logic [PB-1:0] phase_step;
  logic [LB-1:0] envelope;
  logic          active;

  logic [PB-1:0]                phase_cur;
  logic [PB-1:0]                step_cur;
  logic [LB-1:0]                env_cur;
  logic                         active_cur;
  logic [PW-1:0]                decay_sum;
  logic [LB-1:0]                env_dec;
  logic                         env_quiet;
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-1:0]   tab_k;

  // A trigger restarts the voice before this frame's sample is taken.
  always_comb begin
    if (frame.click_start) begin
      phase_cur  = '0;
      step_cur   = frame.accent ? accent_step : beat_step;
      env_cur    = frame.accent ? accent_level : beat_level;
      active_cur = 1'b1;
    end else begin
      phase_cur  = phase;
      step_cur   = phase_step;
      env_cur    = envelope;
      active_cur = active;
    end
  end

  // Round half up back to Q0.24 after the decay multiply.
  assign decay_sum = PW'(env_cur) * PW'(decay_factor) + PW'(1 << (LB - 1));
  assign env_dec   = decay_sum[PW-1:LB];
  assign env_quiet = env_dec < silence_level;

  // Quadrant from the top phase bits; odd quadrants walk the table backward.
  assign quad     = phase_cur[PB-1:PB-2];
  assign tab_k    = phase_cur[PB-3 -: SINE_TABLE_BITS];
  assign tab_addr = quad[0] ? (AW'(QTR_LEN) - {1'b0, tab_k}) : {1'b0, tab_k};
  assign tab_re   = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      envelope   <= '0;
      active     <= 1'b0;
    end else if (take && active_cur) begin
      phase      <= phase_cur + step_cur;
      phase_step <= step_cur;
      envelope   <= env_quiet ? '0 : env_dec;
      active     <= !env_quiet;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: table read in flight; hold envelope, sign and input samples
  // ---------------------------------------------------------------------
  logic [LB-1:0]        env1;
  logic                 neg1;
  logic                 von1;
  logic signed [SB-1:0] left1;
  logic signed [SB-1:0] right1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= take;
    end
  end

  // A silent voice carries a zero envelope so its click comes out as zero.
  always_ff @(posedge clk) begin
    if (take) begin
      env1   <= active_cur ? env_cur : '0;
      neg1   <= active_cur && quad[1];
      von1   <= active_cur && !env_quiet;
      left1  <= frame.in_left;
      right1 <= frame.in_right;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sine times envelope
  // ---------------------------------------------------------------------
  logic [PW-1:0]        prod2;
  logic                 neg2;
  logic                 von2;
  logic signed [SB-1:0] left2;
  logic signed [SB-1:0] right2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      prod2  <= PW'(tab_q) * PW'(env1);
      neg2   <= neg1;
      von2   <= von1;
      left2  <= left1;
      right2 <= right1;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: round the click, apply its sign, mix and saturate
  // ---------------------------------------------------------------------
  function automatic logic signed [SB-1:0] sat_sample(input logic signed [SW-1:0] v);
    logic signed [SB-1:0] r;
    if ((v[SW-1:SB-1] == '0) || (v[SW-1:SB-1] == '1)) begin
      r = v[SB-1:0];
    end else if (v[SW-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  logic [PW:0]          click_rnd;
  logic [SB-1:0]        click_mag;
  logic signed [SB:0]   click_pos;
  logic signed [SB:0]   click;
  logic signed [SW-1:0] sum_left;
  logic signed [SW-1:0] sum_right;

  assign click_rnd = {1'b0, prod2} + ((PW + 1)'(1) << (SH - 1));
  assign click_mag = click_rnd[SH +: SB];
  assign click_pos = signed'({1'b0, click_mag});
  assign click     = neg2 ? -click_pos : click_pos;
  assign sum_left  = SW'(left2) + SW'(click);
  assign sum_right = SW'(right2) + SW'(click);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (en_o) begin
      mix_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v2) begin
      mix.out_left  <= sat_sample(sum_left);
      mix.out_right <= sat_sample(sum_right);
      mix.voice_on  <= von2;
    end
  end

endmodule

### sv/mcv_checker.sv
// Port-level checks on the metronome click voice, bound to its top level.
`timescale 1ns / 1ps

module mcv_checker (
  input logic            clk,
  input logic            rst,
  input logic            frame_valid,
  input logic            frame_ready,
  input logic            mix_valid,
  input logic            mix_ready,
  input mcv_pkg::mix_t   mix
);

  localparam int CW = $clog2(mcv_pkg::PIPE_DEPTH + 1) + 1;

  logic [CW-1:0] in_flight;
  logic          beat_in;
  logic          beat_out;

  assign beat_in  = frame_valid && frame_ready;
  assign beat_out = mix_valid && mix_ready;

  // Track beats taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CW'(beat_in) - CW'(beat_out);
    end
  end

  a_mix_hold: assert property (@(posedge clk) disable iff (rst)
    mix_valid && !mix_ready |=> mix_valid)
    else $error("mix beat dropped while stalled");

  a_mix_stable: assert property (@(posedge clk) disable iff (rst)
    mix_valid && !mix_ready |=> $stable(mix))
    else $error("mix payload changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    mix_valid |-> in_flight != '0)
    else $error("mix beat with no frame in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CW'(mcv_pkg::PIPE_DEPTH))
    else $error("more frames in flight than pipeline stages");

endmodule

bind metronome_click_voice mcv_checker u_mcv_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame_valid),
  .frame_ready (frame_ready),
  .mix_valid   (mix_valid),
  .mix_ready   (mix_ready),
  .mix         (mix)
);

### tb/sv/click_mix_checker.sv
// Checker: predicts every mixed frame of the click voice and compares it with the mix beats.
`timescale 1ns / 1ps

module click_mix_checker #(
  parameter int SINE_TABLE_BITS = mcv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              frame_valid,
  input  logic                              frame_ready,
  input  mcv_pkg::frame_t                   frame,
  input  logic                              mix_valid,
  input  logic                              mix_ready,
  input  mcv_pkg::mix_t                     mix,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mcv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mcv_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                fail_count,
  output int                                due_count,
  output int                                checked
);

  localparam int QLEN     = 1 << SINE_TABLE_BITS;
  localparam int CLICK_SH = 49 - mcv_pkg::SAMPLE_BITS;
  localparam longint Q24_TOP = 16777215;
  // odd polynomial for sin(pi/2 * x), coefficients in Q2.30
  localparam longint SIN_C1 = 1686629713;
  localparam longint SIN_C3 = 693598668;
  localparam longint SIN_C5 = 85569306;
  localparam longint SIN_C7 = 5026993;
  localparam longint SIN_C9 = 172273;

  logic [mcv_pkg::LEVEL_BITS-1:0] sine_q [0:QLEN];

  logic [mcv_pkg::STEP_BITS-1:0]  acc_step_r, beat_step_r;
  logic [mcv_pkg::LEVEL_BITS-1:0] acc_lvl_r, beat_lvl_r, decay_r, quiet_r;
  logic [mcv_pkg::STEP_BITS-1:0]  ph, ph_inc;
  logic [mcv_pkg::LEVEL_BITS-1:0] env;
  logic                           sounding;

  mcv_pkg::mix_t mix_due [$];
  int            fails;
  int            seen;

  function automatic logic [mcv_pkg::LEVEL_BITS-1:0] quarter_sine(int k);
    longint x, x2, t;
    x  = longint'(k) <<< (30 - SINE_TABLE_BITS);
    x2 = (x * x) >>> 30;
    t  = SIN_C9;
    t  = -SIN_C7 + ((t * x2) >>> 30);
    t  = SIN_C5 + ((t * x2) >>> 30);
    t  = -SIN_C3 + ((t * x2) >>> 30);
    t  = SIN_C1 + ((t * x2) >>> 30);
    t  = (t * x) >>> 30;
    if (t <= 0) return '0;
    t = (t + 32) >>> 6;
    if (t > Q24_TOP) t = Q24_TOP;
    return t[mcv_pkg::LEVEL_BITS-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= QLEN; k++) sine_q[k] = quarter_sine(k);
  end

  function automatic logic [mcv_pkg::SAMPLE_BITS-1:0] clip(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (mcv_pkg::SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[mcv_pkg::SAMPLE_BITS-1:0];
  endfunction

  function automatic int field_diff(string field, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    return 1;
  endfunction

  // Advance the voice by one frame and form the mixed output.
  task automatic voice_frame(input mcv_pkg::frame_t f, output mcv_pkg::mix_t m);
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] k;
    int                         idx;
    logic [63:0]                tab_w, env_w, dec_w, prod, mag;
    longint                     click;
    click = 0;
    if (f.click_start) begin
      ph       = '0;
      ph_inc   = f.accent ? acc_step_r : beat_step_r;
      env      = f.accent ? acc_lvl_r : beat_lvl_r;
      sounding = 1'b1;
    end
    if (sounding) begin
      quad = ph[mcv_pkg::STEP_BITS-1 -: 2];
      k    = ph[mcv_pkg::STEP_BITS-3 -: SINE_TABLE_BITS];
      idx  = int'(k);
      // odd quadrants run the table backwards
      if (quad[0]) idx = QLEN - idx;
      tab_w = 64'(sine_q[idx]);
      env_w = 64'(env);
      dec_w = 64'(decay_r);
      prod  = tab_w * env_w;
      mag   = (prod + (64'd1 << (CLICK_SH - 1))) >> CLICK_SH;
      click = quad[1] ? -$signed(mag) : $signed(mag);
      ph    = ph + ph_inc;
      prod  = env_w * dec_w + (64'd1 << 23);
      env   = prod[mcv_pkg::LEVEL_BITS+23:24];
      if (env < quiet_r) begin
        sounding = 1'b0;
        env      = '0;
      end
    end
    m.out_left  = clip($signed(f.in_left) + click);
    m.out_right = clip($signed(f.in_right) + click);
    m.voice_on  = sounding;
  endtask

  always @(posedge clk) begin : watch
    mcv_pkg::mix_t want;
    if (rst) begin
      acc_step_r  = mcv_pkg::ACCENT_STEP_RST;
      beat_step_r = mcv_pkg::BEAT_STEP_RST;
      acc_lvl_r   = mcv_pkg::ACCENT_LEVEL_RST;
      beat_lvl_r  = mcv_pkg::BEAT_LEVEL_RST;
      decay_r     = mcv_pkg::DECAY_FACTOR_RST;
      quiet_r     = mcv_pkg::SILENCE_LEVEL_RST;
      ph          = '0;
      ph_inc      = '0;
      env         = '0;
      sounding    = 1'b0;
      mix_due.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (mix_valid && mix_ready) begin
        seen++;
        if (mix_due.size() == 0) begin
          $display("%0t: mix beat L %0d R %0d on %0b arrived with nothing expected",
                   $time, $signed(mix.out_left), $signed(mix.out_right), mix.voice_on);
          fails++;
        end else begin
          want = mix_due.pop_front();
          fails += field_diff("out_left", $signed(want.out_left), $signed(mix.out_left));
          fails += field_diff("out_right", $signed(want.out_right), $signed(mix.out_right));
          fails += field_diff("voice_on", int'(want.voice_on), int'(mix.voice_on));
        end
      end
      // A frame taken at the same edge as a register write still sees the old value.
      if (frame_valid && frame_ready) begin
        voice_frame(frame, want);
        mix_due.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mcv_pkg::REG_ACCENT_STEP:   acc_step_r  = cfg_data[mcv_pkg::STEP_BITS-1:0];
          mcv_pkg::REG_BEAT_STEP:     beat_step_r = cfg_data[mcv_pkg::STEP_BITS-1:0];
          mcv_pkg::REG_ACCENT_LEVEL:  acc_lvl_r   = cfg_data[mcv_pkg::LEVEL_BITS-1:0];
          mcv_pkg::REG_BEAT_LEVEL:    beat_lvl_r  = cfg_data[mcv_pkg::LEVEL_BITS-1:0];
          mcv_pkg::REG_DECAY_FACTOR:  decay_r     = cfg_data[mcv_pkg::LEVEL_BITS-1:0];
          mcv_pkg::REG_SILENCE_LEVEL: quiet_r     = cfg_data[mcv_pkg::LEVEL_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    due_count  <= mix_due.size();
    checked    <= seen;
  end

endmodule

### tb/sv/metronome_click_voice_tb.sv
// Testbench top: drives frames and register writes into the click voice and gives the verdict.
`timescale 1ns / 1ps

module metronome_click_voice_tb;

  localparam int TABLE_BITS = mcv_pkg::SINE_TABLE_BITS_DEF;
  localparam int SB         = mcv_pkg::SAMPLE_BITS;
  localparam int IW         = mcv_pkg::CFG_IDX_BITS;
  localparam int CDW        = mcv_pkg::CFG_DATA_BITS;
  // The table build after reset moves no beat while it runs; allow three times
  // its length before calling the run hung. Every later stall is far shorter.
  localparam int IDLE_LIMIT = 3 * 12 * ((1 << TABLE_BITS) + 1) + 1000;
  // Indexes past the last register: writes there must change nothing.
  localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_RUNS} rx_mode_t;

  logic            clk         = 1'b0;
  logic            rst         = 1'b1;
  logic            frame_valid = 1'b0;
  logic            frame_ready;
  mcv_pkg::frame_t frame       = '0;
  logic            mix_valid;
  logic            mix_ready   = 1'b0;
  mcv_pkg::mix_t   mix;
  logic            cfg_valid   = 1'b0;
  logic            cfg_ready;
  logic [IW-1:0]   cfg_index   = '0;
  logic [CDW-1:0]  cfg_data    = '0;

  rx_mode_t    rx_mode     = RX_RANDOM;
  int unsigned rx_tick     = 0;
  int          rx_hold     = 0;
  int          idle_cycles = 0;
  int          fail_count;
  int          due_count;
  int          mixes_checked;
  int          frames_sent = 0;
  int          clicks_sent = 0;
  int          writes_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  metronome_click_voice #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .mix_valid   (mix_valid),
    .mix_ready   (mix_ready),
    .mix         (mix),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  click_mix_checker #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) i_check (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .mix_valid   (mix_valid),
    .mix_ready   (mix_ready),
    .mix         (mix),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .due_count   (due_count),
    .checked     (mixes_checked)
  );

  // Mix-side back-pressure. Each mode stalls differently so that output gaps land
  // on every stage of the pipeline: none, random, a fixed 3-of-8 comb, and long
  // runs where ready toggles only when its random hold count runs out.
  always @(posedge clk) begin
    if (rst) begin
      mix_ready <= 1'b0;
      rx_tick   <= 0;
      rx_hold   <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_ALWAYS:   mix_ready <= 1'b1;
        RX_RANDOM:   mix_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: mix_ready <= ((rx_tick % 8) >= 3);
        default: begin
          if (rx_hold == 0) begin
            mix_ready <= ~mix_ready;
            rx_hold   <= $urandom_range(1, 12);
          end else begin
            rx_hold <= rx_hold - 1;
          end
        end
      endcase
    end
  end

  // Watchdog: end the run once no beat has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (frame_valid && frame_ready) || (mix_valid && mix_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d mix beats still due",
               $time, IDLE_LIMIT, due_count);
      $display("** metronome_click_voice: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic mcv_pkg::frame_t make_frame(bit start, bit acc, int left, int right);
    mcv_pkg::frame_t f;
    f.click_start = start;
    f.accent      = acc;
    f.in_left     = left[SB-1:0];
    f.in_right    = right[SB-1:0];
    return f;
  endfunction

  // Mostly uniform samples; a quarter sit at the rails so that clicks clip.
  function automatic int pick_sample();
    int full;
    full = 1 << (SB - 1);
    case ($urandom_range(0, 7))
      0:       return full - 1 - $urandom_range(0, 3);
      1:       return -full + $urandom_range(0, 3);
      default: return $urandom_range(0, 2 * full - 1) - full;
    endcase
  endfunction

  // Trigger odds are per thousand frames; accent is random even without a trigger.
  function automatic mcv_pkg::frame_t random_frame(int start_odds);
    return make_frame($urandom_range(0, 999) < start_odds, 1'($urandom_range(0, 1)),
                      pick_sample(), pick_sample());
  endfunction

  // Present one frame and hold it until accepted. Valid stays high on return so
  // that back-to-back frames never drop it between beats.
  task automatic send_frame(input mcv_pkg::frame_t f);
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (!frame_ready) @(posedge clk);
    frames_sent++;
    if (f.click_start) clicks_sent++;
  endtask

  // Send random frames in bursts of 1..40 with idle gaps bounded by gap_max.
  task automatic play_frames(input int count, input int start_odds, input int gap_max);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = $urandom_range(0, gap_max);
        if (gap != 0) begin
          frame_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_frame(random_frame(start_odds));
      burst--;
    end
  endtask

  // Drop valid and hold until every expected mix beat is back, then let the
  // pipeline settle. The first edge lets the checker count the last frame.
  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (mcv_pkg::PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // One register write; valid drops for a cycle afterwards.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [CDW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Opening frames on the reset register values. Frame ready stays low while
    // the sine table is built; send_frame simply waits that out.
    send_frame(make_frame(1'b0, 1'b0, -32768, 32767));   // silent voice: pass through
    send_frame(make_frame(1'b0, 1'b1, 32767, -32768));   // accent without trigger: ignore
    send_frame(make_frame(1'b0, 1'b0, 0, -1));
    send_frame(make_frame(1'b1, 1'b0, 0, 0));            // beat click starts at phase zero
    repeat (3) send_frame(make_frame(1'b0, 1'b0, 100, -100));
    frame_valid <= 1'b0;
    repeat (2) @(posedge clk);
    send_frame(make_frame(1'b1, 1'b1, 32767, -32768));   // retrigger while sounding
    // positive click on a full-scale left channel must clip high
    repeat (6) send_frame(make_frame(1'b0, 1'b0, 32767, -32768));
    send_frame(make_frame(1'b1, 1'b1, -32768, 32767));
    drain();

    // Extreme register values, plus writes past the last register that must
    // leave everything as it is.
    write_reg(mcv_pkg::REG_ACCENT_STEP, 32'hFFFF_FFFF);
    write_reg(mcv_pkg::REG_BEAT_STEP, 32'h0000_0000);
    write_reg(mcv_pkg::REG_ACCENT_LEVEL, 32'h00FF_FFFF);
    write_reg(mcv_pkg::REG_BEAT_LEVEL, 32'h0000_0000);
    write_reg(mcv_pkg::REG_DECAY_FACTOR, 32'h00FF_FFFF);
    write_reg(mcv_pkg::REG_SILENCE_LEVEL, 32'h0000_0000);
    write_reg(REG_SPARE_LO, 32'h0000_0001);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    rx_mode <= RX_PERIODIC;
    play_frames(300, 30, 4);
    drain();

    // Zero decay and a top silence level: every click sounds for exactly one
    // frame. Junk above bit 23 must be masked off.
    write_reg(mcv_pkg::REG_ACCENT_STEP, $urandom());
    write_reg(mcv_pkg::REG_BEAT_STEP, $urandom());
    write_reg(mcv_pkg::REG_ACCENT_LEVEL, $urandom());
    write_reg(mcv_pkg::REG_BEAT_LEVEL, $urandom());
    write_reg(mcv_pkg::REG_DECAY_FACTOR, 32'hFF00_0000);
    write_reg(mcv_pkg::REG_SILENCE_LEVEL, 32'hFFFF_FFFF);
    rx_mode <= RX_RUNS;
    play_frames(300, 300, 6);

    // Random voicings with clicks that die out within tens to thousands of
    // frames. Pause halfway through each until the pipeline is empty.
    for (int r = 0; r < 3; r++) begin
      drain();
      write_reg(mcv_pkg::REG_ACCENT_STEP, $urandom());
      write_reg(mcv_pkg::REG_BEAT_STEP, $urandom());
      write_reg(mcv_pkg::REG_ACCENT_LEVEL, $urandom());
      write_reg(mcv_pkg::REG_BEAT_LEVEL, $urandom());
      write_reg(mcv_pkg::REG_DECAY_FACTOR,
                ($urandom() & 32'hFF00_0000) | $urandom_range(32'hE0_0000, 32'hFF_F000));
      write_reg(mcv_pkg::REG_SILENCE_LEVEL, $urandom_range(0, 32'h1_0000));
      rx_mode <= rx_mode_t'(r + 1);
      play_frames(175, 20, 8);
      drain();
      play_frames(175, 20, 8);
    end
    drain();

    // Back to the reset values, with both sides running flat out.
    write_reg(mcv_pkg::REG_ACCENT_STEP, CDW'(mcv_pkg::ACCENT_STEP_RST));
    write_reg(mcv_pkg::REG_BEAT_STEP, CDW'(mcv_pkg::BEAT_STEP_RST));
    write_reg(mcv_pkg::REG_ACCENT_LEVEL, CDW'(mcv_pkg::ACCENT_LEVEL_RST));
    write_reg(mcv_pkg::REG_BEAT_LEVEL, CDW'(mcv_pkg::BEAT_LEVEL_RST));
    write_reg(mcv_pkg::REG_DECAY_FACTOR, CDW'(mcv_pkg::DECAY_FACTOR_RST));
    write_reg(mcv_pkg::REG_SILENCE_LEVEL, CDW'(mcv_pkg::SILENCE_LEVEL_RST));
    rx_mode <= RX_ALWAYS;
    play_frames(150, 15, 0);
    drain();

    $display("Sent %0d frames with %0d click triggers and %0d register writes.",
             frames_sent, clicks_sent, writes_done);
    $display("Compared %0d mix beats over reset, extreme, one-frame and random voicings.",
             mixes_checked);
    if (fail_count == 0) begin
      $display("** metronome_click_voice: PASSED **");
    end else begin
      $display("** metronome_click_voice: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
sv/mcv_pkg.sv
sv/mcv_ram.sv
sv/mcv_sine_fill.sv
sv/metronome_click_voice.sv
sv/mcv_checker.sv
tb/sv/click_mix_checker.sv
tb/sv/metronome_click_voice_tb.sv
